// File: design/snfcp_pkg.sv
package snfcp_pkg;

   // Field widths of the request and instruction items.
   localparam int ADDR_W = 24;
   localparam int LEN_W  = 14;
   localparam int OP_W   = 8;

   // Flash geometry and request limits.
   localparam int PAGE_BYTES   = 256;
   localparam int SECTOR_BYTES = 4096;
   localparam int MAX_LENGTH   = 8192;
   localparam int MAX_RESULTS  = 33;

   localparam int PAGE_W   = $clog2(PAGE_BYTES);
   localparam int SECTOR_W = $clog2(SECTOR_BYTES);
   localparam int CNT_W    = $clog2(MAX_RESULTS);

   // Flash instruction opcodes.
   localparam logic [OP_W-1:0] OP_PROGRAM = 8'h02;
   localparam logic [OP_W-1:0] OP_READ    = 8'h03;
   localparam logic [OP_W-1:0] OP_ERASE   = 8'h20;
   localparam logic [OP_W-1:0] OP_ID      = 8'h90;
   localparam logic [OP_W-1:0] OP_WAKE    = 8'hAB;

   localparam logic [ADDR_W-1:0] ID_ADDRESS = 24'hFFFF00;
   localparam logic [LEN_W-1:0]  ID_BYTES   = 14'd2;

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_ERASE   = 2'd1,
      CMD_PROGRAM = 2'd2,
      CMD_OPEN    = 2'd3
   } command_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;
      logic empty;
      logic last;
   } dp_status_type;

endpackage

// File: design/spi_nor_flash_command_planner_top.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  command, start_address, byte_length
// rsp_      out        rsp_valid/rsp_ready  opcode, flash_address, byte_count,
//                                           poll/write-enable flags, last
//
// A request is taken in idle, then its instructions leave at one per cycle from the
// instruction sequencer while the output is not stalled.
// An erase or program of zero length gives no instruction.
// Reset is synchronous and active high; it clears the sequencer and the output valid.
// A stalled output holds the sequencer; the next request is taken while the
// final instruction of the previous one still waits in the output register.
module spi_nor_flash_command_planner_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_command,
   input  logic [snfcp_pkg::ADDR_W-1:0] req_start_address,
   input  logic [snfcp_pkg::LEN_W-1:0]  req_byte_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [snfcp_pkg::OP_W-1:0]   rsp_opcode,
   output logic [snfcp_pkg::ADDR_W-1:0] rsp_flash_address,
   output logic [snfcp_pkg::LEN_W-1:0]  rsp_byte_count,
   output logic                         rsp_poll_ready_before,
   output logic                         rsp_write_enable_before,
   output logic                         rsp_poll_ready_after,
   output logic                         rsp_last
);
   import snfcp_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer.
   snfcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Address, length and instruction datapath.
   snfcp_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .dp_cmd                  (dp_cmd),
      .dp_status               (dp_status),
      .req_command             (req_command),
      .req_start_address       (req_start_address),
      .req_byte_length         (req_byte_length),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_opcode              (rsp_opcode),
      .rsp_flash_address       (rsp_flash_address),
      .rsp_byte_count          (rsp_byte_count),
      .rsp_poll_ready_before   (rsp_poll_ready_before),
      .rsp_write_enable_before (rsp_write_enable_before),
      .rsp_poll_ready_after    (rsp_poll_ready_after),
      .rsp_last                (rsp_last)
   );

endmodule

// File: design/snfcp_ctrl.sv
module snfcp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  snfcp_pkg::dp_status_type dp_status,
   output snfcp_pkg::dp_cmd_type    dp_cmd
);
   import snfcp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_GEN  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Sequence: take a request in idle, then issue one instruction per free cycle.
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      dp_cmd.load = 1'b0;
      dp_cmd.step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_GEN;
            end
         end
         ST_GEN: begin
            if (dp_status.empty) begin
               state_in = ST_IDLE;
            end else if (dp_status.out_free) begin
               dp_cmd.step = 1'b1;
               if (dp_status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/snfcp_datapath.sv
module snfcp_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  snfcp_pkg::dp_cmd_type                  dp_cmd,
   output snfcp_pkg::dp_status_type               dp_status,
   input  logic [1:0]                             req_command,
   input  logic [snfcp_pkg::ADDR_W-1:0]           req_start_address,
   input  logic [snfcp_pkg::LEN_W-1:0]            req_byte_length,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [snfcp_pkg::OP_W-1:0]             rsp_opcode,
   output logic [snfcp_pkg::ADDR_W-1:0]           rsp_flash_address,
   output logic [snfcp_pkg::LEN_W-1:0]            rsp_byte_count,
   output logic                                   rsp_poll_ready_before,
   output logic                                   rsp_write_enable_before,
   output logic                                   rsp_poll_ready_after,
   output logic                                   rsp_last
);
   import snfcp_pkg::*;

   localparam int SEC_CNT_W = ADDR_W + 1 - SECTOR_W;

   // Request state.
   command_type       cmd_ff;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [CNT_W-1:0]  n_ff;

   // Output register.
   logic              valid_ff;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              pb_ff, pb_in;
   logic              we_ff, we_in;
   logic              pa_ff, pa_in;
   logic              last_ff, last_in;

   // Load-time values.
   logic [LEN_W-1:0]     len_clamp;
   logic [ADDR_W:0]      end_byte;
   logic [SEC_CNT_W-1:0] sectors;
   logic [ADDR_W-1:0]    load_cur;
   logic [LEN_W-1:0]     load_left;

   // Step-time values.
   logic [PAGE_W:0]  room;
   logic [LEN_W-1:0] room_ext;
   logic [LEN_W-1:0] chunk;
   logic             cap_hit;

   // Clamp the length and, for an erase, count the sectors the range touches.
   always_comb begin
      len_clamp = (req_byte_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                          : req_byte_length;
      end_byte  = {1'b0, req_start_address} + (ADDR_W+1)'(len_clamp) - (ADDR_W+1)'(1);
      sectors   = end_byte[ADDR_W:SECTOR_W]
                  - {1'b0, req_start_address[ADDR_W-1:SECTOR_W]}
                  + SEC_CNT_W'(1);
      load_cur  = req_start_address;
      load_left = len_clamp;
      if (command_type'(req_command) == CMD_ERASE) begin
         load_cur  = {req_start_address[ADDR_W-1:SECTOR_W], {SECTOR_W{1'b0}}};
         load_left = (len_clamp == '0) ? '0 : LEN_W'(sectors);
      end
   end

   // Build the current instruction and the state after it.
   always_comb begin
      room     = (PAGE_W+1)'(PAGE_BYTES) - {1'b0, cur_ff[PAGE_W-1:0]};
      room_ext = LEN_W'(room);
      chunk    = (left_ff < room_ext) ? left_ff : room_ext;
      cap_hit  = (n_ff == CNT_W'(MAX_RESULTS - 1));
      op_in    = OP_READ;
      addr_in  = cur_ff;
      count_in = left_ff;
      pb_in    = 1'b1;
      we_in    = 1'b0;
      pa_in    = 1'b0;
      last_in  = 1'b1;
      cur_in   = cur_ff;
      left_in  = left_ff;
      case (cmd_ff)
         CMD_READ: begin
            op_in = OP_READ;
         end
         CMD_ERASE: begin
            op_in    = OP_ERASE;
            count_in = '0;
            we_in    = 1'b1;
            last_in  = (left_ff == LEN_W'(1)) || cap_hit;
            cur_in   = cur_ff + ADDR_W'(SECTOR_BYTES);
            left_in  = left_ff - LEN_W'(1);
         end
         CMD_PROGRAM: begin
            op_in    = OP_PROGRAM;
            count_in = chunk;
            we_in    = 1'b1;
            last_in  = (left_ff == chunk) || cap_hit;
            cur_in   = cur_ff + ADDR_W'(chunk);
            left_in  = left_ff - chunk;
         end
         CMD_OPEN: begin
            pb_in = 1'b0;
            if (n_ff == '0) begin
               op_in    = OP_WAKE;
               addr_in  = '0;
               count_in = '0;
               pa_in    = 1'b1;
               last_in  = 1'b0;
            end else begin
               op_in    = OP_ID;
               addr_in  = ID_ADDRESS;
               count_in = ID_BYTES;
            end
         end
         default: begin
            op_in = OP_READ;
         end
      endcase
   end

   // Status toward the controller.
   assign dp_status.out_free = !valid_ff || rsp_ready;
   assign dp_status.empty    = ((cmd_ff == CMD_ERASE) || (cmd_ff == CMD_PROGRAM))
                               && (left_ff == '0);
   assign dp_status.last     = last_in;

   // Request state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else if (dp_cmd.load) begin
         n_ff <= '0;
      end else if (dp_cmd.step) begin
         n_ff <= n_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff  <= command_type'(req_command);
         cur_ff  <= load_cur;
         left_ff <= load_left;
      end else if (dp_cmd.step) begin
         cur_ff  <= cur_in;
         left_ff <= left_in;
      end
   end

   // Output register: a new instruction enters when the old one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (dp_cmd.step) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.step) begin
         op_ff    <= op_in;
         addr_ff  <= addr_in;
         count_ff <= count_in;
         pb_ff    <= pb_in;
         we_ff    <= we_in;
         pa_ff    <= pa_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid               = valid_ff;
   assign rsp_opcode              = op_ff;
   assign rsp_flash_address       = addr_ff;
   assign rsp_byte_count          = count_ff;
   assign rsp_poll_ready_before   = pb_ff;
   assign rsp_write_enable_before = we_ff;
   assign rsp_poll_ready_after    = pa_ff;
   assign rsp_last                = last_ff;

endmodule

// File: design/snfcp_checker.sv
module snfcp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [snfcp_pkg::OP_W-1:0]   rsp_opcode,
   input logic [snfcp_pkg::ADDR_W-1:0] rsp_flash_address,
   input logic [snfcp_pkg::LEN_W-1:0]  rsp_byte_count,
   input logic                         rsp_poll_ready_before,
   input logic                         rsp_write_enable_before,
   input logic                         rsp_poll_ready_after,
   input logic                         rsp_last
);
   import snfcp_pkg::*;

   // A stalled instruction holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_opcode)
         && $stable(rsp_flash_address) && $stable(rsp_byte_count)
         && $stable(rsp_poll_ready_before) && $stable(rsp_write_enable_before)
         && $stable(rsp_poll_ready_after) && $stable(rsp_last))
      else $error("stalled instruction changed");

   // Nothing is offered right after reset.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("instruction valid after reset");

   // A read and an id read always close their request.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_opcode == OP_READ || rsp_opcode == OP_ID) |-> rsp_last)
      else $error("read or id read without last");

   // A program chunk is never empty, never longer than a page and carries write enable.
   a_page_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opcode == OP_PROGRAM |->
         rsp_byte_count != '0 && rsp_byte_count <= LEN_W'(PAGE_BYTES)
         && rsp_write_enable_before)
      else $error("bad program chunk");

   // An erase starts on a sector boundary and moves no data.
   a_erase_base: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opcode == OP_ERASE |->
         rsp_flash_address[SECTOR_W-1:0] == '0 && rsp_byte_count == '0)
      else $error("bad erase instruction");

endmodule

bind spi_nor_flash_command_planner_top snfcp_checker u_snfcp_checker (.*);
